>>> rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/tccu_pkg.sv
// Package of types and constants for the text console cursor engine.
`timescale 1ns / 1ps

package tccu_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Field widths.
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Character and attribute codes.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_BACK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_RESULT
  } state_e;

  // Cursor update and the memory work that one request asks for.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              wr_en;
    logic              wr_blank;
    logic [ADDR_W-1:0] wr_addr;
    logic              scroll;
    logic              clear;
  } cursor_upd_t;

endpackage

>>> rtl/tccu_cursor.sv
// Cursor movement logic: next cursor position and cell write for one request.
`timescale 1ns / 1ps

module tccu_cursor (
  input  logic [1:0]                 action_i,
  input  logic [7:0]                 char_code_i,
  input  logic [tccu_pkg::ROW_W-1:0] row_i,
  input  logic [tccu_pkg::COL_W-1:0] col_i,
  output logic [tccu_pkg::POS_W-1:0] cur_pos_o,
  output tccu_pkg::cursor_upd_t      upd_o
);
  import tccu_pkg::*;

  logic [COL_W:0] col_n;
  logic [ROW_W:0] row_n;

  // Linear position of the present cursor.
  assign cur_pos_o = POS_W'(row_i) * POS_W'(COLUMNS) + POS_W'(col_i);

  // Work out the new cursor and any cell write.
  always_comb begin
    col_n          = {1'b0, col_i};
    row_n          = {1'b0, row_i};
    upd_o.wr_en    = 1'b0;
    upd_o.wr_blank = 1'b0;
    upd_o.wr_addr  = ADDR_W'(cur_pos_o);
    upd_o.scroll   = 1'b0;
    upd_o.clear    = 1'b0;
    case (action_e'(action_i))
      ACT_PUT: begin
        if (char_code_i == CHAR_NEWLINE) begin
          col_n = '0;
          row_n = {1'b0, row_i} + 1'b1;
        end else if (char_code_i == CHAR_RETURN) begin
          col_n = '0;
        end else begin
          upd_o.wr_en = 1'b1;
          col_n       = {1'b0, col_i} + 1'b1;
        end
        // Wrap at the line end.
        if (col_n >= (COL_W+1)'(COLUMNS)) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end
        // Moving below the last row scrolls the screen.
        if (row_n >= (ROW_W+1)'(ROWS)) begin
          upd_o.scroll = 1'b1;
          row_n        = (ROW_W+1)'(ROWS - 1);
        end
      end
      ACT_BACK: begin
        // Stepping back lands one cell before the cursor, even across a row; at the first cell nothing changes.
        upd_o.wr_addr = ADDR_W'(cur_pos_o) - 1'b1;
        if (col_i != '0) begin
          col_n          = {1'b0, col_i} - 1'b1;
          upd_o.wr_en    = 1'b1;
          upd_o.wr_blank = 1'b1;
        end else if (row_i != '0) begin
          row_n          = {1'b0, row_i} - 1'b1;
          col_n          = (COL_W+1)'(COLUMNS - 1);
          upd_o.wr_en    = 1'b1;
          upd_o.wr_blank = 1'b1;
        end
      end
      ACT_CLEAR: begin
        upd_o.clear = 1'b1;
        col_n       = '0;
        row_n       = '0;
      end
      ACT_READ: begin
        col_n = {1'b0, col_i};
      end
      default: begin
        col_n = {1'b0, col_i};
      end
    endcase
    upd_o.row = row_n[ROW_W-1:0];
    upd_o.col = col_n[COL_W-1:0];
  end

endmodule

>>> rtl/text_console_cursor_engine_unit.sv
// Top level of the text console engine: screen memory, sequencer and result register.
`timescale 1ns / 1ps

// Text console engine. A request on the input channel (in_valid_i, held while
// in_stall_o is high) carries an action: put character, backspace, clear or
// read cell. Each request gives exactly one result on the output channel
// (out_valid_o, held while out_stall_i is high) with the cursor after the
// action and, for a read, the stored cell word, or zero for an index off the screen.
// For put character without scroll, backspace and read cell, the cell write or
// read happens in the accepting cycle and the result register is loaded from
// the result state once the output register is free. Clear and any put that
// scrolls sweep all 2000 cells through the single write port of the screen
// memory, one a cycle; a scroll copies the cell a row further on into each cell and blanks the last row.
// After reset a clearing pass writes a blank with attribute 07h into every
// cell; requests are held off meanwhile, while writes to the attribute
// register are taken at any time.
// A request is taken while an earlier result still waits in the output
// register; its own result waits in the sequencer until that register frees.
module text_console_cursor_engine_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [7:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [7:0]                  char_code_i,
  input  logic [10:0]                 cell_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tccu_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [tccu_pkg::COL_W-1:0]  cursor_col_o,
  output logic [tccu_pkg::POS_W-1:0]  cursor_pos_o,
  output logic [tccu_pkg::CELL_W-1:0] cell_value_o
);
  import tccu_pkg::*;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [7:0]        attr_q;
  logic              out_valid_q, out_valid_d;
  logic              pend_valid_q, pend_valid_d;
  logic              pend_copy_q, pend_copy_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic              is_read_q, hit_q;
  logic [CELL_W-1:0] rdata_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [POS_W-1:0]  out_pos_q;
  logic [CELL_W-1:0] out_cell_q;

  logic [CELL_W-1:0] screen_q [CELL_COUNT];

  logic              accept;
  logic              last;
  logic              out_free;
  logic              load_out;
  logic              idx_hit;
  logic              copy_phase;
  logic [CELL_W-1:0] blank;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [POS_W-1:0]  cur_pos;
  cursor_upd_t       upd;

  tccu_cursor u_cursor (
    .action_i    (action_i),
    .char_code_i (char_code_i),
    .row_i       (row_q),
    .col_i       (col_q),
    .cur_pos_o   (cur_pos),
    .upd_o       (upd)
  );

  // Handshake and sweep conditions.
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign last       = (cnt_q == ADDR_W'(CELL_COUNT - 1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign idx_hit    = (cell_index_i < 11'(CELL_COUNT));
  assign copy_phase = (cnt_q < ADDR_W'(CELL_COUNT - COLUMNS));
  assign blank      = {attr_q, BLANK_CHAR};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (upd.clear) begin
            state_d = ST_CLEAR;
          end else if (upd.scroll) begin
            state_d = ST_SCROLL;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SCROLL, ST_CLEAR: begin
        if (last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // Sequencer outputs: memory ports, sweep counter and the scroll pipeline.
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    load_out     = 1'b0;
    cnt_d        = cnt_q;
    mem_re       = 1'b0;
    mem_raddr    = ADDR_W'(cell_index_i);
    pend_valid_d = 1'b0;
    pend_copy_d  = 1'b0;
    pend_addr_d  = cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q;
    mem_wdata    = blank;
    case (state_q)
      ST_INIT: begin
        cnt_d     = cnt_q + 1'b1;
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, BLANK_CHAR};
      end
      ST_IDLE: begin
        if (accept) begin
          cnt_d     = '0;
          mem_re    = (action_e'(action_i) == ACT_READ) && idx_hit;
          mem_we    = upd.wr_en;
          mem_waddr = upd.wr_addr;
          mem_wdata = {attr_q, upd.wr_blank ? BLANK_CHAR : char_code_i};
        end
      end
      ST_SCROLL: begin
        // Read the cell one row down now and write it in the next cycle; the last row gets blanks.
        cnt_d        = cnt_q + 1'b1;
        mem_re       = copy_phase;
        mem_raddr    = cnt_q + ADDR_W'(COLUMNS);
        pend_valid_d = 1'b1;
        pend_copy_d  = copy_phase;
      end
      ST_CLEAR: begin
        cnt_d  = cnt_q + 1'b1;
        mem_we = 1'b1;
      end
      ST_RESULT: begin
        load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    // The scroll write follows its read in the next cycle and owns the write port.
    if (pend_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = pend_copy_q ? rdata_q : blank;
    end
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cnt_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      attr_q       <= RESET_ATTR;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) attr_q <= cfg_wdata_i;
      if (accept) begin
        row_q <= upd.row;
        col_q <= upd.col;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_copy_q <= pend_copy_d;
    pend_addr_q <= pend_addr_d;
    if (accept) begin
      is_read_q <= (action_e'(action_i) == ACT_READ);
      hit_q     <= idx_hit;
    end
    if (load_out) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_pos_q  <= cur_pos;
      out_cell_q <= (is_read_q && hit_q) ? rdata_q : '0;
    end
  end

  // Screen memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) screen_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= screen_q[mem_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cursor_pos_o = out_pos_q;
  assign cell_value_o = out_cell_q;

endmodule

>>> rtl/tccu_checker.sv
// Port-level assertions for the text console engine, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tccu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [tccu_pkg::ROW_W-1:0]  cursor_row_o,
  input logic [tccu_pkg::COL_W-1:0]  cursor_col_o,
  input logic [tccu_pkg::POS_W-1:0]  cursor_pos_o
);
  import tccu_pkg::*;

  // A stalled result stays offered.
  `ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")

  // Only one request is in work at a time.
  `ASSERT_CLK(a_one_in_flight, in_valid_i && !in_stall_o |=> in_stall_o, "second request taken")

  // The reported cursor lies on the screen.
  `ASSERT_CLK(a_cursor_range, out_valid_o |-> (cursor_row_o < ROW_W'(ROWS)) && (cursor_col_o < COL_W'(COLUMNS)), "cursor off screen")

  // The linear position agrees with row and column.
  `ASSERT_CLK(a_pos_match, out_valid_o |-> cursor_pos_o == POS_W'(cursor_row_o) * POS_W'(COLUMNS) + POS_W'(cursor_col_o), "cursor position mismatch")

endmodule

bind text_console_cursor_engine_unit tccu_checker u_tccu_checker (.*);
